@@ rtl/fq_pkg.sv @@
// ----------------------------------------------------------------------------
// fq_pkg: shared types and constants for the bounded search-and-remove FIFO
// Item structs, operation and status codes, and cell control.
// ----------------------------------------------------------------------------
package fq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 16;
    localparam int STAMP_W = 32;
    localparam int POS_W   = 4;
    localparam int GRP     = 4;
    localparam int GROUPS  = DEPTH / GRP;
    localparam int GRP_W   = $clog2(GRP);
    localparam int GSEL_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        op_t                kind;
        logic [VAL_W-1:0]   item_value;
        logic [STAMP_W-1:0] arrival_time;
        logic [POS_W-1:0]   position;
    } fq_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   out_value;
        logic [STAMP_W-1:0] out_time;
        logic [POS_W-1:0]   found_index;
        logic [CNT_W-1:0]   count;
        logic [VAL_W-1:0]   head_value;
        logic [STAMP_W-1:0] head_time;
    } fq_res_t;

    typedef struct packed {
        logic sample;    // register the compare result this cycle
        logic occupied;  // slot lies below the entry count
        logic load;      // take the pushed item
        logic shift;     // take the neighbor's entry
    } fq_cell_ctl_t;

endpackage

@@ rtl/fq_cell.sv @@
// ----------------------------------------------------------------------------
// fq_cell: one queue slot
// Holds one entry, loads a pushed item or its neighbor's entry, and
// registers whether it matches the search key.
// ----------------------------------------------------------------------------
module fq_cell
    import fq_pkg::*;
(
    input  logic               clk,
    input  fq_cell_ctl_t       ctl,
    input  logic [VAL_W-1:0]   key,
    input  logic [VAL_W-1:0]   load_value,
    input  logic [STAMP_W-1:0] load_stamp,
    input  logic [VAL_W-1:0]   next_value,
    input  logic [STAMP_W-1:0] next_stamp,
    output logic [VAL_W-1:0]   value,
    output logic [STAMP_W-1:0] stamp,
    output logic               match
);

    logic [VAL_W-1:0]   value_reg, value_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               match_reg, match_next;

    always_comb
    begin
        value_next = value_reg;
        stamp_next = stamp_reg;
        if (ctl.load)
        begin
            value_next = load_value;
            stamp_next = load_stamp;
        end
        else if (ctl.shift)
        begin
            value_next = next_value;
            stamp_next = next_stamp;
        end
        match_next = ctl.sample ? (ctl.occupied && (value_reg == key)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        stamp_reg <= stamp_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign stamp = stamp_reg;
    assign match = match_reg;

endmodule

@@ rtl/fq_pick.sv @@
// ----------------------------------------------------------------------------
// fq_pick: first-match encoder
// Finds the lowest set match flag, in groups of four, then across groups.
// ----------------------------------------------------------------------------
module fq_pick
    import fq_pkg::*;
(
    input  logic [DEPTH-1:0] match,
    output logic             hit,
    output logic [IDX_W-1:0] index
);

    logic [GROUPS-1:0] grp_any;
    logic [GRP_W-1:0]  grp_idx [GROUPS];
    logic [GSEL_W-1:0] sel;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_any[g] = 1'b0;
            grp_idx[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (match[g * GRP + b])
                begin
                    grp_any[g] = 1'b1;
                    grp_idx[g] = GRP_W'(b);
                end
            end
        end
        sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel = GSEL_W'(g);
            end
        end
        hit   = |grp_any;
        index = IDX_W'({sel, grp_idx[sel]});
    end

endmodule

@@ rtl/bounded_fifo_with_search_and_remove_top.sv @@
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_and_remove_top: bounded FIFO with find and remove-at
// Queue of value/timestamp entries held in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel   signals                 direction  handshake
//  -------   ---------------------   ---------  ------------------------------
//  command   start, busy, cmd        in         accepted when start && !busy
//  result    done, result            out        one-cycle strobe, no stall
//  config    cfg_we, cfg_wdata       in         written when cfg_we is high
//
//  Each item's result strobes in the cycle after acceptance, and a new
//  item may be accepted in every cycle, so the sustained rate is one item
//  per cycle. The cell row updates at the accept edge; the first-match
//  encoder and head read run in the result cycle.
//  Reset clears the entry count, the strobe and the capacity register
//  (back to 16); the cell contents stay undefined and are only read below
//  the count. The receiver cannot stall, so busy stays low.
//
module bounded_fifo_with_search_and_remove_top
    import fq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fq_cmd_t          cmd,
    output logic             done,
    output fq_res_t          result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    // Control and result registers
    logic             done_reg, done_next;
    op_t              op_reg, op_next;
    status_t          status_reg, status_next;
    logic [VAL_W-1:0]   out_value_reg, out_value_next;
    logic [STAMP_W-1:0] out_time_reg, out_time_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] max_entries_reg, max_entries_next;

    logic             accept;
    logic [CNT_W-1:0] cap;
    logic             push_ok;
    logic             rem_req;
    logic             rem_ok;
    logic [IDX_W-1:0] rem_pos;

    // Cell row
    fq_cell_ctl_t       cell_ctl   [DEPTH];
    logic [VAL_W-1:0]   cell_value [DEPTH];
    logic [STAMP_W-1:0] cell_stamp [DEPTH];
    logic [VAL_W-1:0]   feed_value [DEPTH];
    logic [STAMP_W-1:0] feed_stamp [DEPTH];
    logic [DEPTH-1:0]   cell_match;

    logic             find_hit;
    logic [IDX_W-1:0] find_idx;

    // The queue never pushes back on the sender.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Effective capacity is the smaller of the register and the cell count.
    assign cap     = (max_entries_reg < CAP_MAX) ? max_entries_reg : CAP_MAX;
    assign push_ok = (cmd.kind == OP_PUSH) && (count_reg < cap);

    // Pop is remove-at with position zero.
    assign rem_req = (cmd.kind == OP_POP) || (cmd.kind == OP_REMOVE);
    assign rem_pos = (cmd.kind == OP_POP) ? '0 : IDX_W'(cmd.position);
    assign rem_ok  = rem_req && ({{(CNT_W - IDX_W){1'b0}}, rem_pos} < count_reg);

    // Per-cell control: load the slot at the tail, shift every slot at or
    // above the removed position toward the head.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                cell_ctl[gi].sample   = accept;
                cell_ctl[gi].occupied = (CNT_W'(gi) < count_reg);
                cell_ctl[gi].load     = accept && push_ok
                                        && (count_reg == CNT_W'(gi));
                cell_ctl[gi].shift    = accept && rem_ok && (IDX_W'(gi) >= rem_pos);
            end

            if (gi == DEPTH - 1)
            begin : g_last
                // Nothing beyond the last slot: feed zeros.
                assign feed_value[gi] = '0;
                assign feed_stamp[gi] = '0;
            end
            else
            begin : g_mid
                assign feed_value[gi] = cell_value[gi + 1];
                assign feed_stamp[gi] = cell_stamp[gi + 1];
            end

            fq_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl[gi]),
                .key        (cmd.item_value),
                .load_value (cmd.item_value),
                .load_stamp (cmd.arrival_time),
                .next_value (feed_value[gi]),
                .next_stamp (feed_stamp[gi]),
                .value      (cell_value[gi]),
                .stamp      (cell_stamp[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    fq_pick u_pick (
        .match (cell_match),
        .hit   (find_hit),
        .index (find_idx)
    );

    // Next-state: update count and capture removed entry at the accept edge.
    always_comb
    begin
        done_next        = accept;
        op_next          = op_reg;
        status_next      = status_reg;
        out_value_next   = out_value_reg;
        out_time_next    = out_time_reg;
        count_next       = count_reg;
        max_entries_next = cfg_we ? cfg_wdata : max_entries_reg;

        if (accept)
        begin
            op_next        = cmd.kind;
            status_next    = ST_DONE;
            out_value_next = '0;
            out_time_next  = '0;
            unique case (cmd.kind)
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_POP, OP_REMOVE:
                begin
                    if (rem_ok)
                    begin
                        out_value_next = cell_value[rem_pos];
                        out_time_next  = cell_stamp[rem_pos];
                        count_next     = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                OP_FIND:
                begin
                    // Status settles in the result cycle from the match flags.
                    status_next = ST_DONE;
                end
                default:
                begin
                    status_next = ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            count_reg       <= '0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            done_reg        <= done_next;
            count_reg       <= count_next;
            max_entries_reg <= max_entries_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        out_time_reg  <= out_time_next;
    end

    // Result cycle: resolve find, read the head from the first cell.
    always_comb
    begin
        result.status      = status_reg;
        result.found_index = '0;
        if (op_reg == OP_FIND)
        begin
            result.status = find_hit ? ST_DONE : ST_MISS;
            if (find_hit)
            begin
                result.found_index = POS_W'(find_idx);
            end
        end
        result.out_value  = out_value_reg;
        result.out_time   = out_time_reg;
        result.count      = count_reg;
        result.head_value = (count_reg != '0) ? cell_value[0] : '0;
        result.head_time  = (count_reg != '0) ? cell_stamp[0] : '0;
    end

    assign done = done_reg;

endmodule

@@ tb/tb_bounded_fifo_with_search_and_remove_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_search_and_remove_top: self-checking bench for the FIFO
// Drives push/pop/find/remove-at items in random bursts, rewrites the capacity
// between phases, and checks every reply against a typed row or the queue model.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_search_and_remove_top;
    import fq_pkg::*;

    // Run sizing: twelve planned capacity phases plus two random ones.
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MIX_SPAN        = 25;      // items between traffic mix changes
    localparam int IDLE_GUARD      = 2;       // cycles past the last reply
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRINT_LIMIT     = 40;

    // Traffic mixes: fill pushes hard to reach the capacity, drain empties.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_EVEN,
        MIX_DRAIN
    } mix_t;

    // One row of the directed table: either a capacity write or an item,
    // optionally with its reply spelled out.
    typedef struct {
        bit               is_cfg;
        logic [CNT_W-1:0] cfg_val;
        fq_cmd_t          cmd;
        bit               typed;
        fq_res_t          res;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    fq_cmd_t          cmd;
    logic             done;
    fq_res_t          result;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    // Queue model: oldest entry at index 0.
    logic [VAL_W-1:0]   mdl_val  [DEPTH];
    logic [STAMP_W-1:0] mdl_time [DEPTH];
    int                 mdl_len;
    logic [CNT_W-1:0]   mdl_cap;

    fq_res_t  fifo_replies [$];   // predicted replies, oldest first
    dir_row_t dir_rows [$];

    // Literal reply for the item currently on the command port.
    bit      lit_valid;
    fq_res_t lit_res;

    int burst_left;
    int errors;
    int cycle_count;
    int items_sent;
    int replies_checked;
    int cfg_writes;
    int deepest;
    int op_seen [4];
    int st_seen [3];

    bounded_fifo_with_search_and_remove_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Queue model: apply one item, return the reply it must produce.
    // ------------------------------------------------------------------------
    function automatic fq_res_t fifo_model_step(fq_cmd_t c);
        fq_res_t r;
        int      limit;
        int      p;
        int      i;
        bit      hit;
        r = '0;
        r.status = ST_DONE;
        limit = (int'(mdl_cap) < DEPTH) ? int'(mdl_cap) : DEPTH;
        case (c.kind)
            OP_PUSH:
            begin
                // Drop while at or above capacity, including a lowered one.
                if (mdl_len >= limit)
                    r.status = ST_FULL;
                else
                begin
                    mdl_val[mdl_len]  = c.item_value;
                    mdl_time[mdl_len] = c.arrival_time;
                    mdl_len++;
                end
            end
            OP_POP, OP_REMOVE:
            begin
                p = (c.kind == OP_POP) ? 0 : int'(c.position);
                if (p >= mdl_len)
                    r.status = ST_MISS;
                else
                begin
                    r.out_value = mdl_val[p];
                    r.out_time  = mdl_time[p];
                    // Close the gap toward the head.
                    for (i = p; i + 1 < mdl_len; i++)
                    begin
                        mdl_val[i]  = mdl_val[i + 1];
                        mdl_time[i] = mdl_time[i + 1];
                    end
                    mdl_len--;
                end
            end
            default:
            begin
                // First match from the head wins.
                hit = 1'b0;
                for (i = 0; i < mdl_len; i++)
                begin
                    if (!hit && mdl_val[i] == c.item_value)
                    begin
                        hit = 1'b1;
                        r.found_index = POS_W'(i);
                    end
                end
                if (!hit)
                    r.status = ST_MISS;
            end
        endcase
        r.count = CNT_W'(mdl_len);
        if (mdl_len > 0)
        begin
            r.head_value = mdl_val[0];
            r.head_time  = mdl_time[0];
        end
        return r;
    endfunction

    function automatic fq_res_t make_reply(status_t st, logic [VAL_W-1:0] ov,
                                           logic [STAMP_W-1:0] ot, logic [POS_W-1:0] fi,
                                           logic [CNT_W-1:0] cnt, logic [VAL_W-1:0] hv,
                                           logic [STAMP_W-1:0] ht);
        fq_res_t r;
        r.status      = st;
        r.out_value   = ov;
        r.out_time    = ot;
        r.found_index = fi;
        r.count       = cnt;
        r.head_value  = hv;
        r.head_time   = ht;
        return r;
    endfunction

    function automatic fq_cmd_t make_cmd(op_t k, logic [VAL_W-1:0] v,
                                         logic [STAMP_W-1:0] t, logic [POS_W-1:0] p);
        fq_cmd_t c;
        c.kind         = k;
        c.item_value   = v;
        c.arrival_time = t;
        c.position     = p;
        return c;
    endfunction

    // Add an item row; a reply is typed in only where it is obvious.
    function automatic void add_item(fq_cmd_t c, bit typed, fq_res_t r);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_val = '0;
        row.cmd     = c;
        row.typed   = typed;
        row.res     = r;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CNT_W-1:0] v);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        row.cmd     = '0;
        row.typed   = 1'b0;
        row.res     = '0;
        dir_rows.push_back(row);
    endfunction

    // Random item: small values so finds hit, positions mostly in range.
    function automatic fq_cmd_t random_cmd(mix_t mix);
        fq_cmd_t c;
        int      roll;
        int      w_push;
        int      w_pop;
        int      w_find;
        case (mix)
            MIX_FILL:
            begin
                w_push = 60; w_pop = 10; w_find = 15;
            end
            MIX_DRAIN:
            begin
                w_push = 15; w_pop = 35; w_find = 15;
            end
            default:
            begin
                w_push = 25; w_pop = 25; w_find = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_push)
            c.kind = OP_PUSH;
        else if (roll < w_push + w_pop)
            c.kind = OP_POP;
        else if (roll < w_push + w_pop + w_find)
            c.kind = OP_FIND;
        else
            c.kind = OP_REMOVE;
        if ($urandom_range(0, 9) < 7)
            c.item_value = VAL_W'($urandom_range(0, 15));
        else
            c.item_value = VAL_W'($urandom);
        c.arrival_time = $urandom;
        if (mdl_len > 0 && $urandom_range(0, 9) < 7)
            c.position = POS_W'($urandom_range(0, mdl_len - 1));
        else
            c.position = POS_W'($urandom_range(0, 15));
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("[%0t] item %0d: %s got %h expected %h",
                     $realtime, replies_checked, what, got, want);
        errors++;
    endtask

    task automatic check_reply(fq_res_t got, fq_res_t want);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.out_value !== want.out_value)
            report_mismatch("out_value", 32'(got.out_value), 32'(want.out_value));
        if (got.out_time !== want.out_time)
            report_mismatch("out_time", got.out_time, want.out_time);
        if (got.found_index !== want.found_index)
            report_mismatch("found_index", 32'(got.found_index), 32'(want.found_index));
        if (got.count !== want.count)
            report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.head_value !== want.head_value)
            report_mismatch("head_value", 32'(got.head_value), 32'(want.head_value));
        if (got.head_time !== want.head_time)
            report_mismatch("head_time", got.head_time, want.head_time);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check the reply strobed this cycle, then predict the item
    // accepted at this edge. A reply always strobes in the cycle after its
    // item, so checking first keeps the order right when both land on one edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_blk
        fq_res_t want;
        fq_res_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                if (fifo_replies.size() == 0)
                    report_mismatch("reply with nothing pending", 32'(result.count), 32'd0);
                else
                begin
                    want = fifo_replies.pop_front();
                    check_reply(result, want);
                end
                replies_checked++;
            end
            if (start && !busy)
            begin
                pred = fifo_model_step(cmd);
                // Run the model even on typed rows so its state stays current.
                fifo_replies.push_back(lit_valid ? lit_res : pred);
                op_seen[cmd.kind]++;
                if (pred.status <= ST_FULL)
                    st_seen[pred.status]++;
                if (mdl_len > deepest)
                    deepest = mdl_len;
            end
            if (cfg_we)
                mdl_cap = cfg_wdata;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: called at a falling edge, holds the item until accepted, and
    // returns at a falling edge. Bursts of random length end in random gaps;
    // a quarter of the bursts run straight into the next one.
    // ------------------------------------------------------------------------
    task automatic send_item(fq_cmd_t c, bit typed, fq_res_t r);
        int gap;
        start     <= 1'b1;
        cmd       <= c;
        lit_valid = typed;
        lit_res   = r;
        do @(posedge clk); while (busy);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(0, 24);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Write the capacity only once every reply is in and the block is quiet.
    task automatic write_capacity(logic [CNT_W-1:0] v);
        start <= 1'b0;
        while (fifo_replies.size() != 0)
            @(negedge clk);
        repeat (IDLE_GUARD) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stim_blk
        int   cap_plan [12];
        int   ph;
        int   n;
        mix_t mix;
        logic [CNT_W-1:0] cap;

        cap_plan = '{16, 31, 0, 1, 16, 8, 17, 2, 16, 5, 31, 15};

        // Hold every input at a known value from time zero.
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        lit_valid = 1'b0;
        lit_res   = '0;
        mdl_len   = 0;
        mdl_cap   = MAX_ENTRIES_RESET;
        for (n = 0; n < DEPTH; n++)
        begin
            mdl_val[n]  = '0;
            mdl_time[n] = '0;
        end
        burst_left      = 0;
        errors          = 0;
        cycle_count     = 0;
        items_sent      = 0;
        replies_checked = 0;
        cfg_writes      = 0;
        deepest         = 0;
        op_seen         = '{default: 0};
        st_seen         = '{default: 0};

        // Directed table. Empty-queue misses, extreme values, first-match
        // find, remove past the end, zero capacity, and capacity lowered
        // below the count.
        add_item(make_cmd(OP_POP, '0, '0, '0), 1'b1,
                 make_reply(ST_MISS, '0, '0, '0, 5'd0, '0, '0));
        add_item(make_cmd(OP_FIND, '0, '0, '0), 1'b1,
                 make_reply(ST_MISS, '0, '0, '0, 5'd0, '0, '0));
        add_item(make_cmd(OP_REMOVE, '0, '0, '0), 1'b1,
                 make_reply(ST_MISS, '0, '0, '0, 5'd0, '0, '0));
        add_item(make_cmd(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, '0), 1'b1,
                 make_reply(ST_DONE, '0, '0, '0, 5'd1, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_PUSH, 16'h0000, 32'h0000_0000, 4'hF), 1'b1,
                 make_reply(ST_DONE, '0, '0, '0, 5'd2, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_FIND, 16'h0000, '0, '0), 1'b1,
                 make_reply(ST_DONE, '0, '0, 4'd1, 5'd2, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_FIND, 16'hFFFF, '0, '0), 1'b1,
                 make_reply(ST_DONE, '0, '0, 4'd0, 5'd2, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_REMOVE, '0, '0, 4'hF), 1'b1,
                 make_reply(ST_MISS, '0, '0, '0, 5'd2, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_REMOVE, '0, '0, 4'd1), 1'b1,
                 make_reply(ST_DONE, 16'h0000, 32'h0, '0, 5'd1, 16'hFFFF, 32'hFFFF_FFFF));
        add_item(make_cmd(OP_POP, '0, '0, '0), 1'b1,
                 make_reply(ST_DONE, 16'hFFFF, 32'hFFFF_FFFF, '0, 5'd0, '0, '0));
        add_cfg(5'd0);
        add_item(make_cmd(OP_PUSH, 16'hAAAA, 32'h1234_5678, '0), 1'b1,
                 make_reply(ST_FULL, '0, '0, '0, 5'd0, '0, '0));
        add_cfg(5'd2);
        add_item(make_cmd(OP_PUSH, 16'd1, 32'd100, '0), 1'b0, '0);
        add_item(make_cmd(OP_PUSH, 16'd2, 32'd200, '0), 1'b0, '0);
        add_item(make_cmd(OP_PUSH, 16'd3, 32'd300, '0), 1'b1,
                 make_reply(ST_FULL, '0, '0, '0, 5'd2, 16'd1, 32'd100));
        add_cfg(5'd1);
        add_item(make_cmd(OP_PUSH, 16'd4, 32'd400, '0), 1'b1,
                 make_reply(ST_FULL, '0, '0, '0, 5'd2, 16'd1, 32'd100));
        add_item(make_cmd(OP_POP, '0, '0, '0), 1'b0, '0);
        add_item(make_cmd(OP_PUSH, 16'd5, 32'd500, '0), 1'b0, '0);
        add_item(make_cmd(OP_REMOVE, '0, '0, 4'd0), 1'b0, '0);
        add_cfg(5'd31);
        add_item(make_cmd(OP_PUSH, 16'd6, 32'hDEAD_BEEF, 4'h5), 1'b0, '0);
        add_item(make_cmd(OP_FIND, 16'd6, '0, '0), 1'b0, '0);
        add_item(make_cmd(OP_FIND, 16'd7, '0, '0), 1'b0, '0);

        // Hold reset, then release it and stay on the falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].cfg_val);
            else
                send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random phases: each starts with a capacity write, opens with a fill
        // mix to reach the limit, then picks a random mix every 25 items.
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 12)
                cap = CNT_W'(cap_plan[ph]);
            else
                cap = CNT_W'($urandom_range(0, 31));
            write_capacity(cap);
            mix = MIX_FILL;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n > 0 && n % MIX_SPAN == 0)
                    mix = mix_t'($urandom_range(0, 2));
                send_item(random_cmd(mix), 1'b0, '0);
            end
        end

        // Drop start, wait out the remaining replies and a short tail.
        start <= 1'b0;
        while (fifo_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Items %0d (push %0d, pop %0d, find %0d, remove %0d), capacity writes %0d.",
                 items_sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_FIND],
                 op_seen[OP_REMOVE], cfg_writes);
        $display("Replies %0d: done %0d, miss %0d, full %0d; depth %0d; mismatches %0d.",
                 replies_checked, st_seen[ST_DONE], st_seen[ST_MISS], st_seen[ST_FULL],
                 deepest, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
